// ----- rtl/rcpd_pkg.sv -----
// ----------------------------------------------------------------------------
// Radix conversion package
// Shared widths and radix limits for the packed-digit radix converter.
// ----------------------------------------------------------------------------
package rcpd_pkg;

	localparam int PACKED_BITS = 47;
	localparam int RADIX_BITS  = 4;
	localparam int DIGIT_BITS  = 4;

	localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 4'd2;
	localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 4'd10;
	localparam logic [RADIX_BITS-1:0] RADIX_RESET = 4'd8;

	typedef logic [PACKED_BITS-1:0] packed_t;
	typedef logic [DIGIT_BITS-1:0]  digit_t;
	typedef logic [RADIX_BITS-1:0]  radix_t;

endpackage

// ----- rtl/radix_convert_packed_digits.sv -----
// ----------------------------------------------------------------------------
// Radix converter with packed decimal digits
// Rewrites a signed integer in a configurable base from 2 to 10 and returns
// the base-N digits as the decimal digits of a binary number.
// ----------------------------------------------------------------------------
// The block accepts one signed word at a time and converts it in a single
// shared compare-subtract divider that produces one quotient bit per cycle.
// Each base-N digit is one full division by the base; digits are pushed on
// a small stack, least significant first, and then popped most significant
// first into the packed result with one multiply-by-ten-and-add per cycle.
// A non-negative word has at most fifteen digits at the default width (base
// 2). Zero and negative words skip the divider and go straight to the
// result; a negative word returns bad_input = 1 and packed_digits = 0.
// in_ready is high only while no conversion is running; the result sits in
// its own output register, so a new word may be accepted while the previous
// result still waits for out_ready. The radix register resets to 8; values
// below 2 act as 2 and values above 10 act as 10. Write it only while idle.
// Results wider than 47 bits (possible only with VALUE_BITS raised) keep
// their low 47 bits.
// ----------------------------------------------------------------------------
module radix_convert_packed_digits
	import rcpd_pkg::*;
#(
	parameter int VALUE_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// radix register write
	input  logic                         cfg_we,
	input  logic [RADIX_BITS-1:0]        cfg_wdata,
	// input word
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [VALUE_BITS-1:0] value,
	// result word
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [PACKED_BITS-1:0]       packed_digits,
	output logic                         bad_input
);

	// magnitude width of a non-negative word, and the most digits it can have
	localparam int MAG_BITS  = VALUE_BITS - 1;
	localparam int DIGITS    = MAG_BITS;
	localparam int CNT_BITS  = $clog2(MAG_BITS);
	localparam int NDIG_BITS = $clog2(DIGITS + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DIV  = 2'd1;
	localparam logic [1:0] S_POP  = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0]           state_q;
	radix_t               radix_q;
	radix_t               base_q;
	logic [MAG_BITS-1:0]  rest_q;
	digit_t               rem_q;
	logic [CNT_BITS-1:0]  bit_cnt_q;
	logic [NDIG_BITS-1:0] ndig_q;
	digit_t               stack_q [DIGITS];
	packed_t              acc_q;
	logic                 neg_q;
	logic                 out_valid_q;
	packed_t              out_packed_q;
	logic                 out_bad_q;

	logic                 in_fire;
	logic                 out_free;
	logic                 fin_fire;
	logic                 last_bit;
	logic [4:0]           trial;
	logic                 ge;
	digit_t               rem_nx;
	logic [MAG_BITS-1:0]  quot_nx;
	radix_t               base_sat;
	packed_t              acc_nx;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign fin_fire  = (state_q == S_FIN) && out_free;
	assign last_bit  = (bit_cnt_q == CNT_BITS'(MAG_BITS - 1));

	assign out_valid     = out_valid_q;
	assign packed_digits = out_packed_q;
	assign bad_input     = out_bad_q;

	// clamp the configured radix into the supported range
	always_comb begin
		base_sat = radix_q;
		if (radix_q < RADIX_MIN) begin
			base_sat = RADIX_MIN;
		end else if (radix_q > RADIX_MAX) begin
			base_sat = RADIX_MAX;
		end
	end

	// shared divider step: bring down the next magnitude bit, subtract the
	// base when it fits; the remainder always stays below the base
	assign trial   = {rem_q, rest_q[MAG_BITS-1]};
	assign ge      = (trial >= {1'b0, base_q});
	assign rem_nx  = ge ? DIGIT_BITS'(trial - {1'b0, base_q}) : DIGIT_BITS'(trial);
	assign quot_nx = {rest_q[MAG_BITS-2:0], ge};

	// Horner step: acc * 10 + digit, wrapping at the packed width
	assign acc_nx = PACKED_BITS'((acc_q << 3) + (acc_q << 1)
		+ {{(PACKED_BITS-DIGIT_BITS){1'b0}}, stack_q[0]});

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			radix_q     <= RADIX_RESET;
			bit_cnt_q   <= '0;
			ndig_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				radix_q <= cfg_wdata;
			end
			if (fin_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						bit_cnt_q <= '0;
						ndig_q    <= '0;
						// negative or zero words skip straight to the result
						if (value[VALUE_BITS-1] || (value[MAG_BITS-1:0] == '0)) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					bit_cnt_q <= last_bit ? '0 : CNT_BITS'(bit_cnt_q + 1'b1);
					if (last_bit) begin
						ndig_q <= NDIG_BITS'(ndig_q + 1'b1);
						if (quot_nx == '0) begin
							state_q <= S_POP;
						end
					end
				end
				S_POP: begin
					ndig_q <= NDIG_BITS'(ndig_q - 1'b1);
					if (ndig_q == NDIG_BITS'(1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					rest_q <= value[MAG_BITS-1:0];
					neg_q  <= value[VALUE_BITS-1];
					base_q <= base_sat;
					rem_q  <= '0;
					acc_q  <= '0;
				end
			end
			S_DIV: begin
				if (last_bit) begin
					// push the finished digit, restart on the quotient
					rest_q <= quot_nx;
					rem_q  <= '0;
					for (int i = DIGITS - 1; i > 0; i--) begin
						stack_q[i] <= stack_q[i-1];
					end
					stack_q[0] <= rem_nx;
				end else begin
					rest_q <= quot_nx;
					rem_q  <= rem_nx;
				end
			end
			S_POP: begin
				// pop most significant digit first
				acc_q <= acc_nx;
				for (int i = 0; i < DIGITS - 1; i++) begin
					stack_q[i] <= stack_q[i+1];
				end
			end
			default: begin
			end
		endcase
		if (fin_fire) begin
			out_packed_q <= neg_q ? '0 : acc_q;
			out_bad_q    <= neg_q;
		end
	end

	// a flagged result always carries zero
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_input |-> packed_digits == '0)
		else $error("bad_input result with nonzero packed_digits");

	// the divider remainder never reaches the base
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> rem_q < base_q)
		else $error("divider remainder out of range");

	// the digit stack never overflows
	a_ndig_range: assert property (@(posedge clk) disable iff (!arst_n)
		ndig_q <= NDIG_BITS'(DIGITS))
		else $error("digit stack overflow");

	// a negative word goes straight to the result stage
	a_neg_fast: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && value[VALUE_BITS-1] |=> state_q == S_FIN && neg_q)
		else $error("negative word not flagged");

endmodule
